// File: design/vnh_pkg.sv
// shared widths, codes and constants for the vector norm histogram
package vnh_pkg;

   localparam int COORD_W = 16;
   localparam int READ_BIN_W = 7;
   localparam int POINT_BIN_W = 7;
   localparam int COUNT_W = 32;
   localparam int DIM_W = 5;
   localparam int SUM_W = 35;
   localparam int SQ_W = 31;
   localparam int TQ_W = 15;
   localparam int STEP_W = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [SUM_W-1:0] ONE_Q30 = SUM_W'(64'd1 << 30);
   localparam logic [13:0] SCALE_SQ = 14'd10000;

   localparam logic OP_COORD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_DIMENSION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_COUNT = 1'b1;

   localparam logic [DIM_W-1:0] DIMENSION_RESET = 5'd2;
   localparam logic [COUNT_W-1:0] TARGET_COUNT_RESET = 32'd1000000;

   typedef logic [COUNT_W-1:0] count_type;

endpackage

// File: design/vnh_if.sv
// valid/ready channel interfaces for request, response and register writes
interface vnh_req_if import vnh_pkg::*; ();
   logic valid;
   logic ready;
   logic operation;
   logic signed [COORD_W-1:0] coordinate;
   logic [READ_BIN_W-1:0] read_bin;

   modport source (output valid, operation, coordinate, read_bin, input ready);
   modport sink (input valid, operation, coordinate, read_bin, output ready);
endinterface

interface vnh_rsp_if import vnh_pkg::*; ();
   logic valid;
   logic ready;
   logic point_done;
   logic point_inside;
   logic [POINT_BIN_W-1:0] point_bin;
   count_type accepted_total;
   logic run_finished;
   count_type bin_value;

   modport source (output valid, point_done, point_inside, point_bin, accepted_total,
                   run_finished, bin_value, input ready);
   modport sink (input valid, point_done, point_inside, point_bin, accepted_total,
                 run_finished, bin_value, output ready);
endinterface

interface vnh_csr_if import vnh_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/vector_norm_histogram.sv
// top level: norm histogram with bin counters in one synchronous memory
//
// channel   | direction | transfer when       | payload
// req_bus   | in        | valid && ready      | operation, coordinate, read_bin
// rsp_bus   | out       | valid && ready      | point_done .. bin_value, one per request
// csr_bus   | in        | valid (ready high)  | index, data
//
// a coordinate that does not end a point and a finished-run coordinate go from idle straight to the result
// a bin read goes through memory read, data, result
// a point that lands in the ball goes through a multiply, 7 square-root search
// steps, then a read-modify-write of its counter in the bin memory
// after reset the bin memory is cleared one entry a cycle, all BIN_COUNT entries, no requests
// a stalled response holds in its output register while the next request is taken
module vector_norm_histogram import vnh_pkg::*; #(
   parameter int BIN_COUNT = 100,
   parameter int MAX_DIMENSION = 16
) (
   input logic clock,
   input logic reset,
   vnh_req_if.sink req_bus,
   vnh_rsp_if.source rsp_bus,
   vnh_csr_if.sink csr_bus
);

   localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_SEARCH = 3'd4;
   localparam logic [2:0] ST_RMW_RD = 3'd5;
   localparam logic [2:0] ST_RMW_WR = 3'd6;
   localparam logic [2:0] ST_FIN = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [BIN_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [DIM_W-1:0] dimension_ff, dimension_in;
   count_type target_ff, target_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [DIM_W-1:0] idx_ff, idx_in;
   count_type accepted_ff, accepted_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [SQ_W-1:0] pt_sum_ff, pt_sum_in;
   logic [TQ_W-1:0] tq_ff, tq_in;
   logic [POINT_BIN_W-1:0] bin_ff, bin_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic hit_ff, hit_in;
   logic res_done_ff, res_done_in;
   logic res_inside_ff, res_inside_in;
   logic [POINT_BIN_W-1:0] res_bin_ff, res_bin_in;
   count_type res_bval_ff, res_bval_in;
   logic out_done_ff, out_done_in;
   logic out_inside_ff, out_inside_in;
   logic [POINT_BIN_W-1:0] out_bin_ff, out_bin_in;
   count_type out_total_ff, out_total_in;
   logic out_finished_ff, out_finished_in;
   count_type out_bval_ff, out_bval_in;

   count_type mem [BIN_COUNT];
   count_type mem_rdata_ff;
   logic mem_we;
   logic [BIN_W-1:0] mem_waddr;
   count_type mem_wdata;
   logic [BIN_W-1:0] rd_addr;

   logic req_xfer;
   logic rsp_xfer;
   logic signed [2*COORD_W-1:0] sq_s;
   logic [SUM_W:0] sum_add;
   logic [SUM_W-1:0] sum_sat;
   logic [DIM_W-1:0] idx_next;
   logic [DIM_W-1:0] dim_eff;
   logic pt_end;
   logic [44:0] prod;
   logic [POINT_BIN_W-1:0] trial;
   logic [13:0] trial_sq;
   logic [POINT_BIN_W-1:0] bin_next;
   logic [31:0] rb_wide;
   logic [31:0] bin_wide;
   logic [BIN_W-1:0] bin_addr;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_bus.ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.point_done = out_done_ff;
   assign rsp_bus.point_inside = out_inside_ff;
   assign rsp_bus.point_bin = out_bin_ff;
   assign rsp_bus.accepted_total = out_total_ff;
   assign rsp_bus.run_finished = out_finished_ff;
   assign rsp_bus.bin_value = out_bval_ff;

   // coordinate square and saturating accumulate
   assign sq_s = req_bus.coordinate * req_bus.coordinate;
   assign sum_add = {1'b0, sum_ff} + (SUM_W+1)'(sq_s[SQ_W-1:0]);
   assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign idx_next = idx_ff + 1'b1;

   always_comb begin
      if (dimension_ff == '0) begin
         dim_eff = DIM_W'(1);
      end else if (32'(dimension_ff) > MAX_DIMENSION) begin
         dim_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         dim_eff = dimension_ff;
      end
   end

   assign pt_end = (idx_next >= dim_eff) || (idx_next == '0);

   // scaled squared distance and one bit of the square-root search
   assign prod = {14'b0, pt_sum_ff} * {31'b0, SCALE_SQ};
   assign trial = bin_ff | (POINT_BIN_W'(1) << step_ff);
   assign trial_sq = 14'(trial) * 14'(trial);
   assign bin_next = ({1'b0, trial_sq} <= tq_ff) ? trial : bin_ff;

   assign rb_wide = 32'(req_bus.read_bin);
   assign bin_wide = 32'(bin_ff);
   assign bin_addr = bin_wide[BIN_W-1:0];
   assign rd_addr = (state_ff == ST_IDLE) ? rb_wide[BIN_W-1:0] : bin_addr;

   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      dimension_in = dimension_ff;
      target_in = target_ff;
      sum_in = sum_ff;
      idx_in = idx_ff;
      accepted_in = accepted_ff;
      rsp_valid_in = rsp_valid_ff;
      pt_sum_in = pt_sum_ff;
      tq_in = tq_ff;
      bin_in = bin_ff;
      step_in = step_ff;
      hit_in = hit_ff;
      res_done_in = res_done_ff;
      res_inside_in = res_inside_ff;
      res_bin_in = res_bin_ff;
      res_bval_in = res_bval_ff;
      out_done_in = out_done_ff;
      out_inside_in = out_inside_ff;
      out_bin_in = out_bin_ff;
      out_total_in = out_total_ff;
      out_finished_in = out_finished_ff;
      out_bval_in = out_bval_ff;
      mem_we = 1'b0;
      mem_waddr = bin_addr;
      mem_wdata = '0;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_DIMENSION: dimension_in = csr_bus.data[DIM_W-1:0];
            REG_TARGET_COUNT: target_in = csr_bus.data[COUNT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_cnt_ff;
            if (32'(clr_cnt_ff) == BIN_COUNT - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               res_done_in = 1'b0;
               res_inside_in = 1'b0;
               res_bin_in = '0;
               res_bval_in = '0;
               state_in = ST_FIN;
               if (req_bus.operation == OP_READ) begin
                  hit_in = (rb_wide < 32'(BIN_COUNT));
                  state_in = ST_READ;
               end else if (accepted_ff < target_ff) begin
                  sum_in = sum_sat;
                  idx_in = idx_next;
                  if (pt_end) begin
                     sum_in = '0;
                     idx_in = '0;
                     res_done_in = 1'b1;
                     if (sum_sat <= ONE_Q30) begin
                        pt_sum_in = sum_sat[SQ_W-1:0];
                        state_in = ST_MUL;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            res_bval_in = hit_ff ? mem_rdata_ff : '0;
            state_in = ST_FIN;
         end
         ST_MUL: begin
            tq_in = prod[44:30];
            bin_in = '0;
            step_in = STEP_W'(POINT_BIN_W - 1);
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            bin_in = bin_next;
            if (step_ff == '0) begin
               if (32'(bin_next) > BIN_COUNT - 1) begin
                  bin_in = POINT_BIN_W'(BIN_COUNT - 1);
               end
               state_in = ST_RMW_RD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_RMW_RD: begin
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            mem_we = 1'b1;
            mem_wdata = (mem_rdata_ff == '1) ? mem_rdata_ff : mem_rdata_ff + 1'b1;
            accepted_in = accepted_ff + 1'b1;
            res_inside_in = 1'b1;
            res_bin_in = bin_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_done_in = res_done_ff;
               out_inside_in = res_inside_ff;
               out_bin_in = res_bin_ff;
               out_total_in = accepted_ff;
               out_finished_in = (accepted_ff >= target_ff);
               out_bval_in = res_bval_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
         dimension_ff <= DIMENSION_RESET;
         target_ff <= TARGET_COUNT_RESET;
         sum_ff <= '0;
         idx_ff <= '0;
         accepted_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         dimension_ff <= dimension_in;
         target_ff <= target_in;
         sum_ff <= sum_in;
         idx_ff <= idx_in;
         accepted_ff <= accepted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_sum_ff <= pt_sum_in;
      tq_ff <= tq_in;
      bin_ff <= bin_in;
      step_ff <= step_in;
      hit_ff <= hit_in;
      res_done_ff <= res_done_in;
      res_inside_ff <= res_inside_in;
      res_bin_ff <= res_bin_in;
      res_bval_ff <= res_bval_in;
      out_done_ff <= out_done_in;
      out_inside_ff <= out_inside_in;
      out_bin_ff <= out_bin_in;
      out_total_ff <= out_total_in;
      out_finished_ff <= out_finished_in;
      out_bval_ff <= out_bval_in;
   end

   // bin memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[rd_addr];
   end

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_xfer)
      else $error("request taken while busy");

   a_total_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      (accepted_ff == $past(accepted_ff)) || (accepted_ff == $past(accepted_ff) + 1'b1))
      else $error("accepted total jumped");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMW_WR) |-> (bin_wide < 32'(BIN_COUNT)))
      else $error("bin index out of range");

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && step_ff == '0) |=> (state_ff == ST_RMW_RD))
      else $error("square-root search did not end");

   a_fin_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_bus.ready)) |=> rsp_valid_ff)
      else $error("result not loaded");

endmodule

// File: tb/norm_histogram_checker.sv
// response checker for the vector norm histogram: predicts each request's response and compares
module norm_histogram_checker import vnh_pkg::*; #(
   parameter int BIN_COUNT = 100,
   parameter int MAX_DIMENSION = 16
) (
   input logic clock,
   input logic reset,
   vnh_req_if req_bus,
   vnh_rsp_if rsp_bus,
   vnh_csr_if csr_bus,
   output int error_count,
   output int outstanding,
   output int ignored_coordinates,
   output int points_completed,
   output int points_counted,
   output int bin_reads
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic point_done;
      logic point_inside;
      logic [POINT_BIN_W-1:0] point_bin;
      count_type accepted_total;
      logic run_finished;
      count_type bin_value;
   } norm_result_type;

   localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

   count_type bin_tally [BIN_COUNT];
   logic [SUM_W-1:0] sum_of_squares;
   logic [DIM_W-1:0] coord_count;
   count_type points_accepted;
   logic [DIM_W-1:0] dimension_reg;
   count_type target_reg;
   norm_result_type expected_results [$];

   initial begin
      error_count = 0;
      outstanding = 0;
      ignored_coordinates = 0;
      points_completed = 0;
      points_counted = 0;
      bin_reads = 0;
   end

   // largest bin whose lower edge is at or below the distance, clamped to the last bin
   function automatic int unsigned norm_bin(input logic [SUM_W-1:0] sum);
      longint unsigned scaled;
      longint unsigned n;
      int unsigned b;
      scaled = 64'(SCALE_SQ) * 64'(sum);
      b = 0;
      while (b + 1 < BIN_COUNT) begin
         n = 64'(b + 1);
         if (n * n * 64'(ONE_Q30) > scaled) break;
         b++;
      end
      return b;
   endfunction

   function automatic norm_result_type predict_result(input logic op,
                                                      input logic signed [COORD_W-1:0] coord,
                                                      input logic [READ_BIN_W-1:0] rbin);
      norm_result_type r;
      logic [COORD_W:0] mag;
      logic [SUM_W:0] grown;
      int unsigned eff_dim;
      int unsigned b;
      r = '0;
      if (op == OP_READ) begin
         bin_reads++;
         if (rbin < BIN_COUNT) r.bin_value = bin_tally[rbin];
      end else if (points_accepted < target_reg) begin
         mag = {coord[COORD_W-1], coord};
         if (coord[COORD_W-1]) mag = -mag;
         grown = {1'b0, sum_of_squares} + mag * mag;
         sum_of_squares = (grown > SUM_LIMIT) ? SUM_LIMIT : grown[SUM_W-1:0];
         eff_dim = dimension_reg;
         if (eff_dim == 0) eff_dim = 1;
         if (eff_dim > MAX_DIMENSION) eff_dim = MAX_DIMENSION;
         coord_count = coord_count + 1'b1;
         if (coord_count >= eff_dim || coord_count == 0) begin
            r.point_done = 1'b1;
            points_completed++;
            if (sum_of_squares <= ONE_Q30) begin
               b = norm_bin(sum_of_squares);
               r.point_inside = 1'b1;
               r.point_bin = POINT_BIN_W'(b);
               if (bin_tally[b] != '1) bin_tally[b]++;
               points_accepted++;
               points_counted++;
            end
            sum_of_squares = '0;
            coord_count = '0;
         end
      end else begin
         ignored_coordinates++;
      end
      r.accepted_total = points_accepted;
      r.run_finished = (points_accepted >= target_reg);
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      norm_result_type want;
      if (reset) begin
         foreach (bin_tally[i]) bin_tally[i] = '0;
         sum_of_squares = '0;
         coord_count = '0;
         points_accepted = '0;
         dimension_reg = DIMENSION_RESET;
         target_reg = TARGET_COUNT_RESET;
         expected_results.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_DIMENSION: dimension_reg = csr_bus.data[DIM_W-1:0];
               REG_TARGET_COUNT: target_reg = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("response transfer with no request waiting for it");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("point_done", want.point_done, rsp_bus.point_done);
               check_field("point_inside", want.point_inside, rsp_bus.point_inside);
               check_field("point_bin", want.point_bin, rsp_bus.point_bin);
               check_field("accepted_total", want.accepted_total, rsp_bus.accepted_total);
               check_field("run_finished", want.run_finished, rsp_bus.run_finished);
               check_field("bin_value", want.bin_value, rsp_bus.bin_value);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_results.insert(expected_results.size(),
                                    predict_result(req_bus.operation, req_bus.coordinate,
                                                   req_bus.read_bin));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// File: tb/vector_norm_histogram_test.sv
// testbench top for the vector norm histogram: clock, reset, stimulus and verdict
module vector_norm_histogram_test import vnh_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BINS = 100;
   localparam int MAX_DIM = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD = 400;
   localparam int MAX_GAP = 60;
   localparam count_type TARGET_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit long_hold_pending = 1'b0;
   int hold_left = 0;
   int requests_sent = 0;

   int error_count;
   int outstanding;
   int ignored_coordinates;
   int points_completed;
   int points_counted;
   int bin_reads;

   vnh_req_if req_bus ();
   vnh_rsp_if rsp_bus ();
   vnh_csr_if csr_bus ();

   vector_norm_histogram #(
      .BIN_COUNT(BINS),
      .MAX_DIMENSION(MAX_DIM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   norm_histogram_checker #(
      .BIN_COUNT(BINS),
      .MAX_DIMENSION(MAX_DIM)
   ) histogram_check (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus),
      .error_count(error_count),
      .outstanding(outstanding),
      .ignored_coordinates(ignored_coordinates),
      .points_completed(points_completed),
      .points_counted(points_counted),
      .bin_reads(bin_reads)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, outstanding);
         $display("FAIL");
         $finish;
      end
   end

   // response back-pressure, including one long hold-off
   always @(negedge clock) begin
      if (long_hold_pending) begin
         hold_left = LONG_HOLD;
         long_hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(input logic op, input logic signed [COORD_W-1:0] coord,
                               input logic [READ_BIN_W-1:0] rbin);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.coordinate <= coord;
      req_bus.read_bin <= rbin;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic finish_batch();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic configure(input logic [DIM_W-1:0] dim, input count_type target);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= REG_DIMENSION;
      csr_bus.data <= CSR_DATA_W'(dim);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.index <= REG_TARGET_COUNT;
      csr_bus.data <= target;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_phase(input int items, input logic [DIM_W-1:0] dim,
                               input count_type target, input int send_pct,
                               input int stall, input bit hold);
      int unsigned eff;
      int unsigned root;
      int unsigned limit;
      int unsigned pick;
      logic signed [COORD_W-1:0] c;
      finish_batch();
      configure(dim, target);
      send_idle_pct = send_pct;
      stall_pct = stall;
      if (hold) long_hold_pending = 1'b1;
      eff = (dim == 0) ? 1 : (dim > MAX_DIM) ? MAX_DIM : dim;
      root = 1;
      while (root * root < eff) root++;
      limit = 32768 / root;
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_request(OP_READ, COORD_W'($urandom), READ_BIN_W'($urandom_range(127)));
         end else begin
            // mostly points near or inside the unit ball, some full-range noise
            if (pick < 75) begin
               c = COORD_W'(int'($urandom_range(2 * limit - 1)) - int'(limit));
            end else if (pick < 93) begin
               c = COORD_W'($urandom);
            end else begin
               case ($urandom_range(3))
                  0: c = 16'sh8000;
                  1: c = 16'sh7fff;
                  2: c = 16'sh0000;
                  default: c = -16'sd1;
               endcase
            end
            send_request(OP_COORD, c, READ_BIN_W'($urandom_range(127)));
         end
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = OP_COORD;
      req_bus.coordinate = '0;
      req_bus.read_bin = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_DIMENSION;
      csr_bus.data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: empty reads, extremes, exact unit distance, outside point
      send_idle_pct = 30;
      stall_pct = 30;
      send_request(OP_READ, 16'sh0000, 7'd0);
      send_request(OP_READ, 16'sh7fff, 7'd127);
      finish_batch();
      configure(5'd1, TARGET_MAX);
      send_request(OP_COORD, 16'sh7fff, 7'd0);
      send_request(OP_COORD, 16'sh8000, 7'd127);
      send_request(OP_COORD, 16'sh0000, 7'd0);
      send_request(OP_COORD, -16'sd1, 7'd0);
      send_request(OP_COORD, 16'sh4000, 7'd0);
      send_request(OP_READ, 16'sh0000, 7'd99);
      send_request(OP_READ, 16'sh0000, 7'd50);
      finish_batch();
      configure(5'd2, TARGET_MAX);
      send_request(OP_COORD, 16'sh7fff, 7'd0);
      send_request(OP_COORD, 16'sh7fff, 7'd0);
      send_request(OP_COORD, 16'sd23170, 7'd0);
      send_request(OP_COORD, -16'sd23170, 7'd0);
      // dimension lowered with a point half done
      finish_batch();
      configure(5'd3, TARGET_MAX);
      send_request(OP_COORD, 16'sh1000, 7'd0);
      finish_batch();
      configure(5'd1, TARGET_MAX);
      send_request(OP_COORD, 16'sh1000, 7'd0);
      finish_batch();
      configure(5'd0, TARGET_MAX);
      send_request(OP_COORD, -16'sd100, 7'd0);
      // target equal to, then below, the accepted count
      finish_batch();
      configure(5'd2, count_type'(points_counted));
      send_request(OP_COORD, 16'sd1000, 7'd0);
      send_request(OP_READ, 16'sh0000, 7'd17);
      finish_batch();
      configure(5'd2, 32'd1);
      send_request(OP_READ, 16'sh0000, 7'd0);

      random_phase(205, 5'd2, TARGET_MAX, 0, 0, 1'b1);
      random_phase(205, 5'd16, TARGET_MAX, 81, 0, 1'b0);
      random_phase(205, 5'd31, TARGET_MAX, 0, 81, 1'b0);
      random_phase(205, 5'd5, TARGET_MAX, 30, 30, 1'b0);
      random_phase(60, 5'd2, count_type'(points_counted + 8), 0, 0, 1'b0);
      random_phase(205, 5'd1, count_type'($urandom) | 32'h8000_0000, 30, 30, 1'b0);
      random_phase(205, 5'd7, TARGET_MAX, 81, 0, 1'b0);
      random_phase(205, 5'd12, TARGET_MAX, 0, 81, 1'b0);

      finish_batch();
      repeat (40) @(negedge clock);

      $display("%0d requests: %0d bin reads, %0d points completed, %0d counted in the ball",
               requests_sent, bin_reads, points_completed, points_counted);
      $display("%0d coordinates dropped after the target was reached; dimensions 0 to 31",
               ignored_coordinates);
      if (error_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
